### hw/rtl/bavg_pkg.sv
// Shared constants, types and the reciprocal for the block averager.
// Used by the channel interfaces, the lane, the merge stage and the top level.
package bavg_pkg;

	localparam int unsigned NUM_AVG = 10;
	localparam int unsigned NUM_CH  = 4;

	localparam int unsigned MV_W    = 12;
	localparam int unsigned SUM_W   = 16;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned OFF_W   = 17;
	localparam int unsigned TEMP_W  = 18;
	localparam int unsigned CNT_W   = $clog2(NUM_AVG + 1);

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = OFF_W;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

	localparam logic [SCALE_W-1:0]      SCALE_RST  = 16'd4096;
	localparam logic signed [OFF_W-1:0] OFFSET_RST = -17'sd6400;

	// Scaling datapath. The product is shifted right by 8 first, then divided by
	// NUM_AVG through a rounded-up reciprocal that is exact for every dividend.
	localparam int unsigned PROD_W  = SUM_W + SCALE_W;
	localparam int unsigned QIN_W   = PROD_W - 8;
	localparam int unsigned DIV_L   = $clog2(NUM_AVG);
	localparam int unsigned DIV_SH  = QIN_W + DIV_L;
	localparam int unsigned RECIP_W = QIN_W + 1;
	localparam int unsigned RPROD_W = QIN_W + RECIP_W;
	localparam int unsigned Q_W     = RPROD_W - DIV_SH;
	localparam int unsigned T_W     = Q_W + 2;

	localparam logic [63:0] RECIP_WIDE = ((64'd1 << DIV_SH) + NUM_AVG - 1) / NUM_AVG;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

	localparam logic signed [T_W-1:0] T_MAX = T_W'((64'sd1 <<< (TEMP_W - 1)) - 1);
	localparam logic signed [T_W-1:0] T_MIN = -T_MAX - T_W'(1);

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [MV_W-1:0]          mv_t;

	typedef struct packed {
		logic acc;     // add this item's sample to the sum
		logic clr;     // compute tick: capture the sum into stage 1 and clear it
		logic adv_s1;  // stage 1 holds a product to move on to stage 2
	} lane_ctl_t;

endpackage

### hw/rtl/bavg_if.sv
// Valid/ready channel interfaces for sample items and temperature items.
// Depends on bavg_pkg for the field widths.
interface bavg_in_if;
	import bavg_pkg::*;

	logic valid;
	logic ready;
	logic [MV_W-1:0] mv_ch1;
	logic [MV_W-1:0] mv_ch2;
	logic [MV_W-1:0] mv_ch3;
	logic [MV_W-1:0] mv_ch4;

	modport source (output valid, output mv_ch1, output mv_ch2, output mv_ch3,
		output mv_ch4, input ready);
	modport sink (input valid, input mv_ch1, input mv_ch2, input mv_ch3,
		input mv_ch4, output ready);
endinterface

interface bavg_out_if;
	import bavg_pkg::*;

	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temp_ch1;
	logic signed [TEMP_W-1:0] temp_ch2;
	logic signed [TEMP_W-1:0] temp_ch3;
	logic signed [TEMP_W-1:0] temp_ch4;

	modport source (output valid, output temp_ch1, output temp_ch2, output temp_ch3,
		output temp_ch4, input ready);
	modport sink (input valid, input temp_ch1, input temp_ch2, input temp_ch3,
		input temp_ch4, output ready);
endinterface

### hw/rtl/bavg_lane.sv
// One channel lane: running sum, scale multiply, divide by the block length
// and offset with saturation. Depends on bavg_pkg.
module bavg_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bavg_pkg::lane_ctl_t                 ctl,
	input  bavg_pkg::mv_t                       mv,
	input  logic [bavg_pkg::SCALE_W-1:0]        scale,
	input  logic signed [bavg_pkg::OFF_W-1:0]   offset,
	output bavg_pkg::temp_t                     temp
);
	import bavg_pkg::*;

	logic [SUM_W-1:0]   sum_q;
	logic [PROD_W-1:0]  prod_s1;
	logic [Q_W-1:0]     quot_s2;
	logic [RPROD_W-1:0] rprod;
	logic signed [T_W-1:0] t_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clr) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_q + SUM_W'(mv);
		end
	end

	// The sum before clearing is what this block's result is built from.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			prod_s1 <= PROD_W'(sum_q) * PROD_W'(scale);
		end
		if (ctl.adv_s1) begin
			quot_s2 <= rprod[RPROD_W-1 -: Q_W];
		end
	end

	assign rprod = RPROD_W'(prod_s1[PROD_W-1:8]) * RPROD_W'(RECIP);

	always_comb begin
		t_sum = $signed({{(T_W - Q_W){1'b0}}, quot_s2})
			+ $signed({{(T_W - OFF_W){offset[OFF_W-1]}}, offset});
		priority if (t_sum > T_MAX) begin
			temp = T_MAX[TEMP_W-1:0];
		end else if (t_sum < T_MIN) begin
			temp = T_MIN[TEMP_W-1:0];
		end else begin
			temp = t_sum[TEMP_W-1:0];
		end
	end

endmodule

### hw/rtl/bavg_merge.sv
// Output stage: gathers the four lane temperatures into one result item and
// holds it until the sink takes it. Depends on bavg_pkg and bavg_out_if.
module bavg_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bavg_pkg::temp_t  lane_temp [bavg_pkg::NUM_CH],
	bavg_out_if.source       temps
);
	import bavg_pkg::*;

	logic  valid_q;
	temp_t temp_q [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (temps.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			temp_q <= lane_temp;
		end
	end

	assign temps.valid    = valid_q;
	assign temps.temp_ch1 = temp_q[0];
	assign temps.temp_ch2 = temp_q[1];
	assign temps.temp_ch3 = temp_q[2];
	assign temps.temp_ch4 = temp_q[3];

endmodule

### hw/rtl/four_channel_block_average_scaler_unit.sv
// Four-channel block averager with linear calibration, top level.
// Sample items are taken one per cycle while samples.ready is high; every
// (NUM_AVG+1)th item is the compute tick, whose result passes the stage 1
// product, stage 2 quotient and merge output registers before it is valid.
// A compute tick is held off until the previous result has been taken and the
// two-stage scaling pipeline (multiply, reciprocal multiply) is empty.
// Reset clears the sums, the sample counter and the valid flags, and loads the
// calibration registers with their default scale and offset.
module four_channel_block_average_scaler_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bavg_in_if.sink                              samples,
	bavg_out_if.source                           temps,
	input  logic                                 cfg_we,
	input  logic [bavg_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [bavg_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bavg_pkg::*;

	logic [SCALE_W-1:0]      scale_q;
	logic signed [OFF_W-1:0] offset_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    valid_s1;
	logic                    valid_s2;
	logic                    full;
	logic                    busy;
	logic                    accept;
	lane_ctl_t               ctl;
	mv_t                     mv [NUM_CH];
	temp_t                   lane_temp [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			offset_q <= OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				REG_OFFSET: offset_q <= $signed(cfg_data[OFF_W-1:0]);
				default: ;
			endcase
		end
	end

	assign full   = (cnt_q == CNT_W'(NUM_AVG));
	assign busy   = valid_s1 | valid_s2 | temps.valid;
	assign samples.ready = !full || !busy;
	assign accept = samples.valid && samples.ready;

	assign ctl.acc    = accept && !full;
	assign ctl.clr    = accept && full;
	assign ctl.adv_s1 = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				cnt_q <= '0;
			end else if (ctl.acc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			valid_s1 <= ctl.clr;
			valid_s2 <= valid_s1;
		end
	end

	assign mv[0] = samples.mv_ch1;
	assign mv[1] = samples.mv_ch2;
	assign mv[2] = samples.mv_ch3;
	assign mv[3] = samples.mv_ch4;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		bavg_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.mv     (mv[i]),
			.scale  (scale_q),
			.offset (offset_q),
			.temp   (lane_temp[i])
		);
	end

	bavg_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s2),
		.lane_temp (lane_temp),
		.temps     (temps)
	);

endmodule
